@@ design/assert_macros.svh @@
// Assertion macros shared by the design files.
// Depends on nothing; the caller provides clk and rst in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef NO_ASSERTIONS
// Checked outside reset.
`define CHK_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every edge, reset included.
`define CHK_ASSERT_ALWAYS(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define CHK_ASSERT(lbl, prop, msg)
`define CHK_ASSERT_ALWAYS(lbl, prop, msg)
`endif
`endif

@@ design/bppq_pkg.sv @@
// Shared types and constants of the beam-pruned priority queue.
// Depends on nothing.
package bppq_pkg;
  localparam int CAPACITY_DEF  = 64;
  localparam int KEY_WIDTH_DEF = 32;
  localparam int TAG_WIDTH_DEF = 32;
  localparam int CNT_MAX_W     = 11;   // holds a count up to 2047
  localparam int CFG_W         = 7;
  localparam int CFG_IDX_W     = 1;

  localparam logic [1:0] OP_PUSH = 2'd0;
  localparam logic [1:0] OP_POP  = 2'd1;
  localparam logic [1:0] OP_BEAM = 2'd2;
  localparam logic [1:0] OP_FIND = 2'd3;

  localparam logic [CFG_IDX_W-1:0] REG_BEAM_WIDTH = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BEAM_DEPTH = 1'd1;

  localparam logic [CFG_W-1:0] BEAM_WIDTH_RST = 7'd1;
  localparam logic [CFG_W-1:0] BEAM_DEPTH_RST = 7'd64;

  typedef enum logic [1:0] {
    MODE_HOLD = 2'd0,
    MODE_PUSH = 2'd1,
    MODE_LEFT = 2'd2
  } cell_mode_t;

  // Broadcast to every cell each cycle.
  typedef struct packed {
    cell_mode_t             mode;
    logic                   head_gt;  // head key above the new key
    logic [CNT_MAX_W-1:0]   count;    // stored entries
    logic [CNT_MAX_W-1:0]   limit;    // cells below this index shift left
  } cell_cmd_t;
endpackage

@@ design/bppq_cell.sv @@
// One slot of the sorted chain: holds key, tag and expanded flag.
// Depends on bppq_pkg.
module bppq_cell #(
  parameter int INDEX     = 0,
  parameter int KEY_WIDTH = 32,
  parameter int TAG_WIDTH = 32
) (
  input  logic                   clk,
  input  bppq_pkg::cell_cmd_t    cmd,
  input  logic [KEY_WIDTH-1:0]   ins_key,
  input  logic [TAG_WIDTH-1:0]   ins_tag,
  input  logic                   ins_exp,
  input  logic [KEY_WIDTH-1:0]   prev_key,
  input  logic [TAG_WIDTH-1:0]   prev_tag,
  input  logic                   prev_exp,
  input  logic                   prev_shift,
  input  logic [KEY_WIDTH-1:0]   next_key,
  input  logic [TAG_WIDTH-1:0]   next_tag,
  input  logic                   next_exp,
  output logic [KEY_WIDTH-1:0]   cell_key,
  output logic [TAG_WIDTH-1:0]   cell_tag,
  output logic                   cell_exp,
  output logic                   shift
);
  import bppq_pkg::*;

  localparam logic [CNT_MAX_W-1:0] IDX = CNT_MAX_W'(INDEX);

  logic lt;

  // Cell sits at or after the insertion point of the pushed entry.
  always_comb begin
    lt = $signed(cell_key) < $signed(ins_key);
    if (INDEX == 0) begin
      shift = (cmd.count == '0) | cmd.head_gt;
    end else begin
      shift = cmd.head_gt | (IDX >= cmd.count) | ~lt;
    end
  end

  always_ff @(posedge clk) begin
    case (cmd.mode)
      MODE_PUSH: begin
        if (shift && !prev_shift) begin
          cell_key <= ins_key;
          cell_tag <= ins_tag;
          cell_exp <= ins_exp;
        end else if (shift) begin
          cell_key <= prev_key;
          cell_tag <= prev_tag;
          cell_exp <= prev_exp;
        end
      end
      MODE_LEFT: begin
        if (IDX < cmd.limit) begin
          cell_key <= next_key;
          cell_tag <= next_tag;
          cell_exp <= next_exp;
        end
      end
      default: ;
    endcase
  end
endmodule

@@ design/beam_pruned_priority_queue_core.sv @@
// Top level of the beam-pruned priority queue: control and the cell chain.
// Depends on bppq_pkg, bppq_cell and assert_macros.svh.
//
// Usage:
//   An item (op, key, entry_tag, expanded_flag) is taken when start is high
//   and busy is low. One result per item is shown on the result ports for
//   one cycle, marked by done; the receiver cannot stall, so it must take it.
//   Push and pop: the chain of cells shifts as the item is taken, and the
//   result follows in the next cycle.
//   Find: the chain rotates once all the way round past the head, then the
//   result is shown.
//   Beam cut: each stored entry in turn is judged at the head while kept
//   entries gather at the tail, then the chain rotates to bring them back
//   to the head, then the result is shown.
//   Registers beam_width (index 0) and beam_depth (index 1) are written on
//   cfg_valid and cfg_ready; cfg_ready is always high.
//   Reset empties the list, sets beam_width to 1 and beam_depth to 64.
module beam_pruned_priority_queue_core #(
  parameter int CAPACITY  = bppq_pkg::CAPACITY_DEF,
  parameter int KEY_WIDTH = bppq_pkg::KEY_WIDTH_DEF,
  parameter int TAG_WIDTH = bppq_pkg::TAG_WIDTH_DEF,
  localparam int CW = $clog2(CAPACITY + 1),
  localparam int PW = $clog2(CAPACITY)
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           start,
  output logic                           busy,
  input  logic [1:0]                     op,
  input  logic signed [KEY_WIDTH-1:0]    key,
  input  logic [TAG_WIDTH-1:0]           entry_tag,
  input  logic                           expanded_flag,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [bppq_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bppq_pkg::CFG_W-1:0]     cfg_data,
  output logic                           done,
  output logic                           found,
  output logic signed [KEY_WIDTH-1:0]    out_key,
  output logic [TAG_WIDTH-1:0]           out_tag,
  output logic                           out_expanded,
  output logic [PW-1:0]                  position,
  output logic [CW-1:0]                  kept_width,
  output logic [CW-1:0]                  kept_depth,
  output logic [CW-1:0]                  entry_count,
  output logic                           dropped
);
  import bppq_pkg::*;

  localparam logic [CW-1:0] CAP_C = CW'(CAPACITY);

  typedef enum logic [4:0] {
    S_IDLE = 5'b00001,
    S_FIND = 5'b00010,
    S_SCAN = 5'b00100,
    S_ROT  = 5'b01000,
    S_DONE = 5'b10000
  } state_t;

  state_t               state;
  logic [1:0]           op_r;
  logic [KEY_WIDTH-1:0] new_key;
  logic [CW-1:0]        count;
  logic [CW-1:0]        step;     // scan or find position
  logic [CW-1:0]        rot;      // rotations left
  logic [CW-1:0]        wcnt;
  logic [CW-1:0]        dcnt;
  logic [CFG_W-1:0]     beam_width;
  logic [CFG_W-1:0]     beam_depth;
  logic                 drop_r;
  logic                 hit;
  logic [KEY_WIDTH-1:0] hit_key;
  logic [TAG_WIDTH-1:0] hit_tag;
  logic [PW-1:0]        hit_pos;

  logic [KEY_WIDTH-1:0] ck [CAPACITY];
  logic [TAG_WIDTH-1:0] ct [CAPACITY];
  logic                 ce [CAPACITY];
  logic                 sh [CAPACITY];
  cell_cmd_t            cmd;

  logic accept;
  logic keep;
  logic unexp;
  logic [CW-1:0] n_next;

  assign accept    = start && !busy;
  assign busy      = (state != S_IDLE);
  assign cfg_ready = 1'b1;
  assign done      = (state == S_DONE);

  // Beam cut decision on the entry at the head.
  always_comb begin
    unexp = ~ce[0];
    keep  = 1'b1;
    if (32'(dcnt) == 32'(beam_depth)) begin
      keep = 1'b0;
    end else if (unexp && (32'(wcnt) == 32'(beam_width))) begin
      keep = 1'b0;
    end
    n_next = keep ? dcnt + 1'b1 : dcnt;
  end

  // Command to the chain.
  always_comb begin
    cmd.mode    = MODE_HOLD;
    cmd.head_gt = $signed(ck[0]) > $signed(accept ? key : new_key);
    cmd.count   = CNT_MAX_W'(count);
    cmd.limit   = CNT_MAX_W'(CAPACITY);
    case (state)
      S_IDLE: begin
        if (accept && op == OP_PUSH) cmd.mode = MODE_PUSH;
        if (accept && op == OP_POP)  cmd.mode = MODE_LEFT;
      end
      S_FIND, S_ROT: cmd.mode = MODE_LEFT;
      S_SCAN: begin
        cmd.mode = MODE_LEFT;
        if (!keep) cmd.limit = CNT_MAX_W'(CAPACITY) - CNT_MAX_W'(dcnt);
      end
      default: ;
    endcase
  end

  // Chain of cells; the tail takes the head back in rotation.
  for (genvar i = 0; i < CAPACITY; i++) begin : g_cell
    localparam int NX = (i == CAPACITY - 1) ? 0 : i + 1;
    localparam int PV = (i == 0) ? 0 : i - 1;
    bppq_cell #(
      .INDEX    (i),
      .KEY_WIDTH(KEY_WIDTH),
      .TAG_WIDTH(TAG_WIDTH)
    ) u_cell (
      .clk       (clk),
      .cmd       (cmd),
      .ins_key   (key),
      .ins_tag   (entry_tag),
      .ins_exp   (expanded_flag),
      .prev_key  (ck[PV]),
      .prev_tag  (ct[PV]),
      .prev_exp  (ce[PV]),
      .prev_shift((i == 0) ? 1'b0 : sh[PV]),
      .next_key  (ck[NX]),
      .next_tag  (ct[NX]),
      .next_exp  (ce[NX]),
      .cell_key  (ck[i]),
      .cell_tag  (ct[i]),
      .cell_exp  (ce[i]),
      .shift     (sh[i])
    );
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      beam_width <= BEAM_WIDTH_RST;
      beam_depth <= BEAM_DEPTH_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_BEAM_WIDTH: beam_width <= cfg_data;
        REG_BEAM_DEPTH: beam_depth <= cfg_data;
        default: ;
      endcase
    end
  end

  // Sequencer.
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      count <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (accept) begin
            op_r    <= op;
            new_key <= key;
            drop_r  <= 1'b0;
            hit     <= 1'b0;
            wcnt    <= '0;
            dcnt    <= '0;
            step    <= '0;
            case (op)
              OP_PUSH: begin
                drop_r <= (count == CAP_C);
                if (sh[CAPACITY-1] && count != CAP_C) count <= count + 1'b1;
                state <= S_DONE;
              end
              OP_POP: begin
                if (count != '0) count <= count - 1'b1;
                state <= S_DONE;
              end
              OP_FIND: state <= S_FIND;
              default: state <= (count == '0) ? S_DONE : S_SCAN;
            endcase
          end
        end
        S_FIND: begin
          if (step < count && !ce[0] && !hit) begin
            hit     <= 1'b1;
            hit_key <= ck[0];
            hit_tag <= ct[0];
            hit_pos <= step[PW-1:0];
          end
          step <= step + 1'b1;
          if (step == CAP_C - 1'b1) state <= S_DONE;
        end
        S_SCAN: begin
          if (keep) begin
            dcnt <= dcnt + 1'b1;
            if (unexp) wcnt <= wcnt + 1'b1;
          end
          step <= step + 1'b1;
          if (step == count - 1'b1) begin
            count <= n_next;
            rot   <= CAP_C - n_next;
            state <= (n_next == CAP_C) ? S_DONE : S_ROT;
          end
        end
        S_ROT: begin
          rot <= rot - 1'b1;
          if (rot == CW'(1)) state <= S_DONE;
        end
        S_DONE: state <= S_IDLE;
        default: state <= S_IDLE;
      endcase
    end
  end

  // Result fields.
  always_comb begin
    found        = 1'b0;
    out_key      = '0;
    out_tag      = '0;
    out_expanded = 1'b0;
    position     = '0;
    kept_width   = '0;
    kept_depth   = '0;
    entry_count  = count;
    dropped      = 1'b0;
    case (op_r)
      OP_PUSH, OP_POP: begin
        if (count != '0) begin
          found        = 1'b1;
          out_key      = ck[0];
          out_tag      = ct[0];
          out_expanded = ce[0];
        end
        dropped = (op_r == OP_PUSH) && drop_r;
      end
      OP_FIND: begin
        if (hit) begin
          found    = 1'b1;
          out_key  = hit_key;
          out_tag  = hit_tag;
          position = hit_pos;
        end
      end
      default: begin
        kept_width = wcnt;
        kept_depth = dcnt;
      end
    endcase
  end

`include "assert_macros.svh"
  `CHK_ASSERT(a_accept_busy, (start && !busy) |=> busy, "accepted item did not raise busy")
  `CHK_ASSERT(a_done_single, done |=> !done, "result strobe longer than one cycle")
  `CHK_ASSERT(a_push_found, (done && op_r == OP_PUSH) |-> found, "push left list empty")
  `CHK_ASSERT(a_count_cap, count <= CAP_C, "entry count above capacity")
endmodule

@@ tb/beam_pruned_priority_queue_core_test.sv @@
// Self-checking testbench for the beam-pruned priority queue core.
// Depends on bppq_pkg and beam_pruned_priority_queue_core.
`timescale 1ns / 1ps

module beam_pruned_priority_queue_core_test;
  import bppq_pkg::*;

  localparam int CAP = 64;

  logic        clk;
  logic        rst;
  logic        start;
  logic        busy;
  logic [1:0]  op;
  logic signed [31:0] key;
  logic [31:0] entry_tag;
  logic        expanded_flag;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [CFG_W-1:0]     cfg_data;
  logic        done;
  logic        found;
  logic signed [31:0] out_key;
  logic [31:0] out_tag;
  logic        out_expanded;
  logic [5:0]  position;
  logic [6:0]  kept_width;
  logic [6:0]  kept_depth;
  logic [6:0]  entry_count;
  logic        dropped;

  typedef struct {
    logic               found;
    logic signed [31:0] k;
    logic [31:0]        t;
    logic               x;
    logic [5:0]         pos;
    logic [6:0]         kw;
    logic [6:0]         kd;
    logic [6:0]         cnt;
    logic               drop;
  } queue_report_t;

  // Shadow copy of the sorted list and the beam registers
  logic signed [31:0] shadow_key [CAP];
  logic [31:0]        shadow_tag [CAP];
  logic               shadow_exp [CAP];
  int                 shadow_count;
  logic [6:0]         shadow_width;
  logic [6:0]         shadow_depth;

  queue_report_t expected_reports[$];
  int            fail_count;

  beam_pruned_priority_queue_core dut (
    .clk(clk), .rst(rst), .start(start), .busy(busy), .op(op), .key(key),
    .entry_tag(entry_tag), .expanded_flag(expanded_flag),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data), .done(done), .found(found), .out_key(out_key),
    .out_tag(out_tag), .out_expanded(out_expanded), .position(position),
    .kept_width(kept_width), .kept_depth(kept_depth),
    .entry_count(entry_count), .dropped(dropped)
  );

  // Clock, period 10 ns
  always begin
    clk = 1'b1;
    #5;
    clk = 1'b0;
    #5;
  end

  // Report entry i of the shadow list
  function automatic void fill_entry(ref queue_report_t r, input int i);
    r.found = 1'b1;
    r.k     = shadow_key[i];
    r.t     = shadow_tag[i];
    r.x     = shadow_exp[i];
    r.pos   = i[5:0];
  endfunction

  // Apply one queue operation to the shadow list and queue its report
  task automatic predict_queue_op(input logic [1:0] o, input logic signed [31:0] k,
                                  input logic [31:0] t, input logic x);
    queue_report_t r;
    int p;
    int i;
    int w;
    int d;
    int n;
    bit ins;
    r = '{default: '0};
    case (o)
      OP_PUSH: begin
        if (shadow_count == 0 || shadow_key[0] > k) begin
          p = 0;
        end else begin
          // a key equal to the head goes behind it
          p = 1;
          while (p < shadow_count && shadow_key[p] < k) p++;
        end
        ins = 1'b1;
        if (shadow_count >= CAP) begin
          r.drop = 1'b1;
          if (p >= CAP) ins = 1'b0;
          else shadow_count = CAP - 1;
        end
        if (ins) begin
          for (i = shadow_count; i > p; i--) begin
            shadow_key[i] = shadow_key[i-1];
            shadow_tag[i] = shadow_tag[i-1];
            shadow_exp[i] = shadow_exp[i-1];
          end
          shadow_key[p] = k;
          shadow_tag[p] = t;
          shadow_exp[p] = x;
          shadow_count++;
        end
        fill_entry(r, 0);
      end
      OP_POP: begin
        if (shadow_count > 0) begin
          for (i = 1; i < shadow_count; i++) begin
            shadow_key[i-1] = shadow_key[i];
            shadow_tag[i-1] = shadow_tag[i];
            shadow_exp[i-1] = shadow_exp[i];
          end
          shadow_count--;
        end
        if (shadow_count > 0) fill_entry(r, 0);
      end
      OP_BEAM: begin
        w = 0;
        d = 0;
        n = 0;
        for (i = 0; i < shadow_count; i++) begin
          if (d == shadow_depth) break;
          if (!shadow_exp[i] && w == shadow_width) continue;
          if (!shadow_exp[i]) w++;
          d++;
          shadow_key[n] = shadow_key[i];
          shadow_tag[n] = shadow_tag[i];
          shadow_exp[n] = shadow_exp[i];
          n++;
        end
        shadow_count = n;
        r.kw = w[6:0];
        r.kd = d[6:0];
      end
      default: begin
        for (i = 0; i < shadow_count; i++) begin
          if (!shadow_exp[i]) begin
            fill_entry(r, i);
            break;
          end
        end
      end
    endcase
    r.cnt = shadow_count[6:0];
    expected_reports.push_back(r);
  endtask

  // Send one item; start stays high so a following item can go back to back
  task automatic send_item(input logic [1:0] o, input logic signed [31:0] k,
                           input logic [31:0] t, input logic x);
    @(negedge clk);
    start         = 1'b1;
    op            = o;
    key           = k;
    entry_tag     = t;
    expanded_flag = x;
    do @(posedge clk); while (busy);
    predict_queue_op(o, k, t, x);
  endtask

  task automatic hold_off(input int cycles);
    @(negedge clk);
    start = 1'b0;
    repeat (cycles) @(negedge clk);
  endtask

  // Wait until every expected report has come
  task automatic drain;
    hold_off(0);
    while (expected_reports.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [6:0] val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_BEAM_WIDTH) shadow_width = val;
    else shadow_depth = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_beam(input logic [6:0] w, input logic [6:0] d);
    drain();
    write_reg(REG_BEAM_WIDTH, w);
    write_reg(REG_BEAM_DEPTH, d);
  endtask

  // Compare each result with the oldest expectation
  always @(posedge clk) begin
    queue_report_t e;
    if (!rst && done) begin
      if (expected_reports.size() == 0) begin
        $error("result with no item pending");
        fail_count++;
      end else begin
        e = expected_reports.pop_front();
        if (found !== e.found) begin
          $error("found exp %0d got %0d", e.found, found); fail_count++;
        end
        if (out_key !== e.k) begin
          $error("out_key exp %h got %h", e.k, out_key); fail_count++;
        end
        if (out_tag !== e.t) begin
          $error("out_tag exp %h got %h", e.t, out_tag); fail_count++;
        end
        if (out_expanded !== e.x) begin
          $error("out_expanded exp %0d got %0d", e.x, out_expanded); fail_count++;
        end
        if (position !== e.pos) begin
          $error("position exp %0d got %0d", e.pos, position); fail_count++;
        end
        if (kept_width !== e.kw) begin
          $error("kept_width exp %0d got %0d", e.kw, kept_width); fail_count++;
        end
        if (kept_depth !== e.kd) begin
          $error("kept_depth exp %0d got %0d", e.kd, kept_depth); fail_count++;
        end
        if (entry_count !== e.cnt) begin
          $error("entry_count exp %0d got %0d", e.cnt, entry_count); fail_count++;
        end
        if (dropped !== e.drop) begin
          $error("dropped exp %0d got %0d", e.drop, dropped); fail_count++;
        end
      end
    end
  end

  // Empty list, tie with the head, key and tag extremes, default beam cut
  task automatic test_ordering;
    send_item(OP_POP, 0, 0, 0);
    send_item(OP_FIND, 0, 0, 0);
    send_item(OP_BEAM, 0, 0, 0);
    send_item(OP_PUSH, 32'sh0001_0000, 32'h1, 1'b1);
    send_item(OP_PUSH, 32'sh0001_0000, 32'h2, 1'b0);
    send_item(OP_PUSH, 32'sh8000_0000, 32'hFFFF_FFFF, 1'b0);
    send_item(OP_PUSH, 32'sh7FFF_FFFF, 32'h0, 1'b1);
    send_item(OP_PUSH, 32'sh8000_0000, 32'hA5A5_5A5A, 1'b1);
    send_item(OP_FIND, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0);
    send_item(OP_FIND, 0, 0, 0);
    send_item(OP_BEAM, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0);
  endtask

  // Width zero, depth zero and registers above any count
  task automatic test_beam_extremes;
    set_beam(7'd0, 7'd127);
    send_item(OP_PUSH, -32'sd5, 32'h10, 1'b0);
    send_item(OP_PUSH, 32'sd9, 32'h11, 1'b1);
    send_item(OP_PUSH, 32'sd3, 32'h12, 1'b0);
    send_item(OP_BEAM, 0, 0, 0);
    send_item(OP_FIND, 0, 0, 0);
    set_beam(7'd127, 7'd0);
    send_item(OP_PUSH, 32'sd1, 32'h13, 1'b0);
    send_item(OP_BEAM, 0, 0, 0);
    send_item(OP_POP, 0, 0, 0);
  endtask

  // Random traffic: bursts and gaps, push weight sets how often the list fills
  task automatic test_random_traffic(input int items, input int push_pct,
                                     input bit gaps);
    int burst;
    int r;
    logic [1:0] o;
    logic signed [31:0] k;
    burst = $urandom_range(1, 8);
    repeat (items) begin
      r = $urandom_range(0, 99);
      if (r < push_pct) o = OP_PUSH;
      else if (r < push_pct + (100 - push_pct) / 2) o = OP_POP;
      else if (r < push_pct + (100 - push_pct) * 3 / 4) o = OP_FIND;
      else o = OP_BEAM;
      // a small pool of keys forces ties, including ties with the head
      if ($urandom_range(0, 1)) k = $signed($urandom_range(0, 6) - 3) <<< 16;
      else k = $urandom;
      send_item(o, k, $urandom, 1'($urandom_range(0, 1)));
      if (gaps) begin
        burst--;
        if (burst == 0) begin
          hold_off($urandom_range(1, 6));
          burst = $urandom_range(1, 8);
        end
      end
    end
  endtask

  initial begin
    fail_count    = 0;
    shadow_count  = 0;
    shadow_width  = BEAM_WIDTH_RST;
    shadow_depth  = BEAM_DEPTH_RST;
    rst           = 1'b1;
    start         = 1'b0;
    op            = OP_PUSH;
    key           = '0;
    entry_tag     = '0;
    expanded_flag = 1'b0;
    cfg_valid     = 1'b0;
    cfg_index     = REG_BEAM_WIDTH;
    cfg_data      = '0;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    test_ordering();
    test_beam_extremes();
    set_beam(7'd1, 7'd64);
    test_random_traffic(250, 85, 1'b1);
    set_beam(7'd64, 7'd64);
    test_random_traffic(250, 70, 1'b0);
    set_beam(7'd0, 7'd127);
    test_random_traffic(200, 60, 1'b1);
    set_beam(7'd127, 7'd0);
    test_random_traffic(150, 60, 1'b1);
    set_beam(7'd3, 7'd10);
    test_random_traffic(250, 65, 1'b1);
    set_beam(7'($urandom_range(0, 127)), 7'($urandom_range(0, 127)));
    test_random_traffic(200, 75, 1'b1);
    set_beam(7'd127, 7'd127);
    test_random_traffic(230, 80, 1'b1);

    drain();
    repeat (200) @(posedge clk);
    if (fail_count == 0 && expected_reports.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Run limit
  initial begin
    #50_000_000;
    $display("TB_ERROR");
    $finish;
  end
endmodule

@@ filelist.f @@
+incdir+design
design/bppq_pkg.sv
design/bppq_cell.sv
design/beam_pruned_priority_queue_core.sv
tb/beam_pruned_priority_queue_core_test.sv
